// ===== rtl/rsp_pkg.sv =====
// Ramp/soak profile package: beat payload types, segment entry type and codes.
// Depends on nothing; used by every file of the block but rsp_stream_if.
`timescale 1ns / 1ps

package rsp_pkg;

  localparam int unsigned MAX_SEGMENTS = 16;
  localparam int unsigned TEMP_W       = 16;
  localparam int unsigned DUR_W        = 32;
  localparam int unsigned PROD_W       = 48;  // |target - prev| * elapsed
  localparam int unsigned QUO_W        = 16;  // quotient never exceeds |target - prev|

  // Item actions
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // Segment kinds
  localparam logic [1:0] KIND_HOLD = 2'd0;
  localparam logic [1:0] KIND_RAMP = 2'd1;

  typedef struct packed {
    logic [1:0]               action;
    logic [1:0]               segment_kind;
    logic signed [TEMP_W-1:0] target_temp;
    logic [DUR_W-1:0]         duration_ms;
    logic [DUR_W-1:0]         query_time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     found;
    logic                     table_full;
  } out_item_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [TEMP_W-1:0] target;
    logic [DUR_W-1:0]         dur;
  } seg_t;

endpackage

// ===== rtl/rsp_stream_if.sv =====
// Valid/ready stream channel carrying one payload type per beat.
// Depends on nothing; the payload type is given at instantiation.
`timescale 1ns / 1ps

interface rsp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rsp_seg_mem.sv =====
// Segment table: one write port, one read port, registered read data.
// Depends on rsp_pkg for the entry type.
`timescale 1ns / 1ps

module rsp_seg_mem #(
  parameter int unsigned Depth = rsp_pkg::MAX_SEGMENTS,
  parameter int unsigned AddrW = 4
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  rsp_pkg::seg_t      wr_data_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output rsp_pkg::seg_t      rd_data_o
);

  rsp_pkg::seg_t segment_table [Depth];

  // Write the appended entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      segment_table[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry a cycle
  always_ff @(posedge clk_i) begin
    rd_data_o <= segment_table[rd_addr_i];
  end

endmodule

// ===== rtl/rsp_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the ramp interpolation.
// Depends on rsp_pkg for operand widths.
`timescale 1ns / 1ps

module rsp_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rsp_pkg::PROD_W-1:0]  dividend_i,
  input  logic [rsp_pkg::DUR_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [rsp_pkg::QUO_W-1:0]   quotient_o
);

  localparam int unsigned StepW = $clog2(rsp_pkg::PROD_W);
  localparam int unsigned RemW  = rsp_pkg::DUR_W + 1;

  logic                       busy_q, done_q;
  logic [StepW-1:0]           step_q;
  logic [rsp_pkg::PROD_W-1:0] quo_q;
  logic [RemW-1:0]            rem_q;
  logic [rsp_pkg::DUR_W-1:0]  div_q;
  logic [RemW-1:0]            shifted, diff;
  logic                       take;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_q[rsp_pkg::DUR_W-1:0], quo_q[rsp_pkg::PROD_W-1]};
    diff    = shifted - {1'b0, div_q};
    take    = shifted >= {1'b0, div_q};
  end

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(rsp_pkg::PROD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[rsp_pkg::PROD_W-2:0], take};
      rem_q <= take ? diff : shifted;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[rsp_pkg::QUO_W-1:0];

endmodule

// ===== rtl/ramp_soak_profile_evaluator.sv =====
// Ramp/soak profile evaluator top level: controller, segment table and divider.
// Depends on rsp_pkg, rsp_stream_if, rsp_seg_mem and rsp_divider.
//
//   port   | modport | payload            | beat
//   -------+---------+--------------------+------------------------------------
//   in_i   | sink    | rsp_pkg::in_item_t | clear, append or query
//   out_o  | source  | rsp_pkg::out_item_t| one result per input beat
//
// For clear and append the result beat is loaded at acceptance.
// A query reads one table entry a cycle; a hold, miss or zero-length ramp ends
// the walk, and an interpolated ramp goes on to a multiply, then the 48-step
// divider. One item is in work at a time.
// Reset empties the table by zeroing the count; entries are not cleared.
// A stalled result holds in the output register; the next input beat is taken
// once that register is free or being emptied.
`timescale 1ns / 1ps

module ramp_soak_profile_evaluator #(
  parameter int unsigned MaxSegments = rsp_pkg::MAX_SEGMENTS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rsp_stream_if.sink   in_i,
  rsp_stream_if.source out_o
);

  localparam int unsigned IdxW   = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CntW   = $clog2(MaxSegments + 1);
  localparam int unsigned StartW = rsp_pkg::DUR_W + $clog2(MaxSegments);
  localparam int unsigned TW     = rsp_pkg::TEMP_W;

  localparam int unsigned StateW = 3;
  localparam logic [StateW-1:0] S_IDLE  = 3'd0;
  localparam logic [StateW-1:0] S_WALK  = 3'd1;
  localparam logic [StateW-1:0] S_MUL   = 3'd2;
  localparam logic [StateW-1:0] S_DIVGO = 3'd3;
  localparam logic [StateW-1:0] S_DIVW  = 3'd4;
  localparam logic [StateW-1:0] S_DONE  = 3'd5;

  logic [StateW-1:0]          state_q, state_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [StartW-1:0]          start_q, start_d;
  logic signed [TW-1:0]       prev_q, prev_d;
  logic [rsp_pkg::DUR_W-1:0]  tq_q, tq_d;
  logic                       sign_q, sign_d;
  logic [TW-1:0]              mag_q, mag_d;
  logic [rsp_pkg::DUR_W-1:0]  el_q, el_d;
  logic [rsp_pkg::DUR_W-1:0]  dur_q, dur_d;
  logic [rsp_pkg::PROD_W-1:0] prod_q, prod_d;
  rsp_pkg::out_item_t         res_q, res_d;
  rsp_pkg::out_item_t         out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic                       in_ready, in_acc, out_free, full_now;
  logic                       wr_en;
  rsp_pkg::seg_t              wr_seg, seg;
  logic [IdxW-1:0]            rd_addr;
  logic [StartW-1:0]          tq_ext, seg_end;
  logic                       hit, last;
  logic signed [TW:0]         diff;
  logic [TW:0]                diff_abs;
  logic                       div_done;
  logic [rsp_pkg::QUO_W-1:0]  quo;
  logic [TW+1:0]              quo_signed, ramp_sum;

  // Handshake
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_ready    = (state_q == S_IDLE) && out_free;
  assign in_acc      = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  // Append goes to the entry at the fill count
  assign full_now      = count_q >= CntW'(MaxSegments);
  assign wr_en         = in_acc && (in_i.payload.action == rsp_pkg::ACT_APPEND) && !full_now;
  assign wr_seg.kind   = in_i.payload.segment_kind;
  assign wr_seg.target = in_i.payload.target_temp;
  assign wr_seg.dur    = in_i.payload.duration_ms;

  // Prefetch the next entry while walking, entry zero otherwise
  assign rd_addr = (state_q == S_WALK) ? idx_q + IdxW'(1) : '0;

  rsp_seg_mem #(
    .Depth (MaxSegments),
    .AddrW (IdxW)
  ) u_seg_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (wr_seg),
    .rd_addr_i (rd_addr),
    .rd_data_o (seg)
  );

  rsp_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIVGO),
    .dividend_i (prod_q),
    .divisor_i  (dur_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Segment match and ramp operands
  always_comb begin
    tq_ext     = StartW'(tq_q);
    seg_end    = start_q + StartW'(seg.dur);
    hit        = ((tq_ext >= start_q) && (tq_ext <= seg_end)) || (seg.dur == '0);
    last       = ({1'b0, count_q} == ((CntW + 1)'(idx_q) + (CntW + 1)'(1)));
    diff       = {seg.target[TW-1], seg.target} - {prev_q[TW-1], prev_q};
    diff_abs   = diff[TW] ? -diff : diff;
    quo_signed = sign_q ? -{2'b00, quo} : {2'b00, quo};
    ramp_sum   = {{2{prev_q[TW-1]}}, prev_q} + quo_signed;
  end

  // Controller
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    start_d     = start_q;
    prev_d      = prev_q;
    tq_d        = tq_q;
    sign_d      = sign_q;
    mag_d       = mag_q;
    el_d        = el_q;
    dur_d       = dur_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_d = '0;
          unique case (in_i.payload.action)
            rsp_pkg::ACT_CLEAR: begin
              count_d     = '0;
              out_valid_d = 1'b1;
            end
            rsp_pkg::ACT_APPEND: begin
              out_d.table_full = full_now;
              if (!full_now) begin
                count_d = count_q + CntW'(1);
              end
              out_valid_d = 1'b1;
            end
            rsp_pkg::ACT_QUERY: begin
              start_d = '0;
              prev_d  = '0;
              idx_d   = '0;
              tq_d    = in_i.payload.query_time_ms;
              res_d   = '0;
              state_d = (count_q == '0) ? S_DONE : S_WALK;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        if (hit && (seg.kind == rsp_pkg::KIND_HOLD)) begin
          res_d.temperature = seg.target;
          res_d.found       = 1'b1;
          state_d           = S_DONE;
        end else if (hit && (seg.kind == rsp_pkg::KIND_RAMP)) begin
          if (seg.dur == '0) begin
            res_d.temperature = seg.target;
            res_d.found       = 1'b1;
            state_d           = S_DONE;
          end else begin
            sign_d  = diff[TW];
            mag_d   = diff_abs[TW-1:0];
            el_d    = rsp_pkg::DUR_W'(tq_ext - start_q);
            dur_d   = seg.dur;
            state_d = S_MUL;
          end
        end else begin
          // Advance past this segment
          start_d = seg_end;
          prev_d  = seg.target;
          if (last) begin
            state_d = S_DONE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      S_MUL: begin
        prod_d  = rsp_pkg::PROD_W'(mag_q) * rsp_pkg::PROD_W'(el_q);
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          res_d.temperature = ramp_sum[TW-1:0];
          res_d.found       = 1'b1;
          state_d           = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and result payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    start_q <= start_d;
    prev_q  <= prev_d;
    tq_q    <= tq_d;
    sign_q  <= sign_d;
    mag_q   <= mag_d;
    el_q    <= el_d;
    dur_q   <= dur_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule

// ===== rtl/rsp_checker.sv =====
// Port-level checks for the ramp/soak profile evaluator, bound to the top.
// Depends on rsp_pkg for action codes.
`timescale 1ns / 1ps

module rsp_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic [1:0]               in_action_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic signed [15:0]       out_temperature_i,
  input logic                     out_found_i,
  input logic                     out_table_full_i
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // Take no input beat while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("input beat taken over a waiting result");

  // Answer a clear or append in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
    (in_action_i == rsp_pkg::ACT_CLEAR || in_action_i == rsp_pkg::ACT_APPEND)
    |=> out_valid_i)
    else $error("no result beat after clear or append");

  // A miss reports zero, and no beat is both a hit and a dropped append
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_found_i || out_temperature_i == '0) &&
                    !(out_found_i && out_table_full_i))
    else $error("inconsistent result beat");

endmodule

bind ramp_soak_profile_evaluator rsp_checker u_rsp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_action_i       (in_i.payload.action),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_temperature_i (out_o.payload.temperature),
  .out_found_i       (out_o.payload.found),
  .out_table_full_i  (out_o.payload.table_full)
);
